// File: hw/rtl/tlsch_pkg.sv
// Shared types and constants for the ClientHello checker.
package tlsch_pkg;

  localparam int MaxMsgBytes = 65536;

  typedef enum logic [4:0] {
    PH_TYPE, PH_BODYLEN, PH_LEGACY, PH_RANDOM, PH_SIDLEN, PH_SID, PH_CSLEN,
    PH_CSITEM, PH_COMPLEN, PH_COMPBYTE, PH_EXTSLEN, PH_EXTTYPE, PH_EXTLEN,
    PH_SKIPEXT, PH_PREFIX, PH_U16ITEM, PH_KSGROUP, PH_KSLEN, PH_KSDATA,
    PH_ALPNLEN, PH_ALPNDATA, PH_SNITYPE, PH_SNILEN, PH_SNIDATA
  } phase_t;

  typedef enum logic [2:0] {
    K_OTHER, K_VERS, K_GROUPS, K_SIGS, K_KEYSHARE, K_ALPN, K_SNI
  } kind_t;

  localparam logic [15:0] ExtSni      = 16'h0000;
  localparam logic [15:0] ExtGroups   = 16'h000a;
  localparam logic [15:0] ExtSigs     = 16'h000d;
  localparam logic [15:0] ExtAlpn     = 16'h0010;
  localparam logic [15:0] ExtVersions = 16'h002b;
  localparam logic [15:0] ExtKeyShare = 16'h0033;
  localparam logic [15:0] KeyLen      = 16'd32;

  localparam logic [1:0] CfgGroup   = 2'd0;
  localparam logic [1:0] CfgSuite   = 2'd1;
  localparam logic [1:0] CfgSig     = 2'd2;
  localparam logic [1:0] CfgVersion = 2'd3;

  // byte queued between front and back
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } qitem_t;

  // one verdict
  typedef struct packed {
    logic        accepted;
    logic        offers_version;
    logic        offers_group;
    logic        offers_sig_scheme;
    logic        offers_suite;
    logic        alpn_seen;
    logic        alpn_has_http11;
    logic [5:0]  session_id_length;
    logic        key_share_found;
    logic [15:0] key_share_offset;
    logic [15:0] host_name_offset;
    logic [15:0] host_name_length;
  } verdict_t;

  function automatic logic [7:0] http11_char(input logic [4:0] idx);
    logic [7:0] c;
    unique case (idx[2:0])
      3'd0: c = 8'h68;
      3'd1: c = 8'h74;
      3'd2: c = 8'h74;
      3'd3: c = 8'h70;
      3'd4: c = 8'h2f;
      3'd5: c = 8'h31;
      3'd6: c = 8'h2e;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/tlsch_queue.sv
// Two-entry byte queue between the front intake and the parser.
module tlsch_queue
  import tlsch_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  qitem_t wr_item,
  output logic   rd_valid,
  input  logic   rd_ready,
  output qitem_t rd_item
);

  qitem_t     mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       wr_fire, rd_fire;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rptr_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wptr_r] <= wr_item;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr_fire) wptr_r <= ~wptr_r;
      if (rd_fire) rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, wr_fire} - {1'b0, rd_fire};
    end
  end

endmodule

// File: hw/rtl/tlsch_front.sv
// Intake: takes message bytes, counts position, marks over-length bytes.
module tlsch_front
  import tlsch_pkg::*;
#(
  parameter int MAX_MSG_BYTES = MaxMsgBytes
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_msg_byte,
  input  logic       in_final_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output qitem_t     q_item,
  output logic       q_over,
  output logic [15:0] q_pos
);
  // position and over flag ride beside the byte in the top level's side queue
  localparam int PW = $clog2(MAX_MSG_BYTES + 1);
  logic [PW-1:0] pos_r;

  assign in_ready    = q_ready;
  assign q_valid     = in_valid;
  assign q_item.data = in_msg_byte;
  assign q_item.fin  = in_final_byte;
  assign q_over      = (pos_r >= PW'(MAX_MSG_BYTES));
  assign q_pos       = pos_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (in_valid && q_ready) begin
      if (in_final_byte) pos_r <= '0;
      else if (!q_over) pos_r <= pos_r + 1'b1;
    end
  end
endmodule

// File: hw/rtl/tlsch_back.sv
// Parser: walks the ClientHello one byte per cycle, unless a verdict waits untaken, and builds the verdict.
module tlsch_back
  import tlsch_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        b_valid,
  output logic        b_ready,
  input  logic [7:0]  b_data,
  input  logic        b_fin,
  input  logic        b_over,
  input  logic [15:0] b_pos,
  input  logic [15:0] wanted_group,
  input  logic [15:0] wanted_suite,
  input  logic [15:0] wanted_sig,
  input  logic [15:0] wanted_version,
  output logic        v_valid,
  input  logic        v_ready,
  output verdict_t    v_data
);

  phase_t      ph_r, ph_nxt;
  logic [23:0] body_r, body_nxt;
  logic [15:0] blk_r, blk_nxt, ext_r, ext_nxt, list_r, list_nxt, ent_r, ent_nxt;
  logic [23:0] sh_r, sh_nxt;
  logic [1:0]  got_r, got_nxt;
  kind_t       kind_r, kind_nxt;
  logic [4:0]  cmp_r, cmp_nxt;
  logic        err_r, err_nxt, hit_r, hit_nxt, seen4_r, seen4_nxt;
  logic [6:0]  fl_r, fl_nxt;
  logic [15:0] ksp_r, ksp_nxt, hp_r, hp_nxt, hl_r, hl_nxt;
  logic [5:0]  sid_r, sid_nxt;
  logic        vv_r;
  verdict_t    vd_r, vd_nxt;

  logic        fire, stop;
  logic [1:0]  w;
  logic [23:0] v;
  logic [15:0] v16, want, p1;
  logic [2:0]  kflag;

  assign b_ready = !vv_r || v_ready;
  assign fire    = b_valid && b_ready;
  assign v_valid = vv_r;
  assign v_data  = vd_r;
  assign v       = {sh_r[15:0], b_data};
  assign v16     = v[15:0];
  assign p1      = b_pos + 16'd1;

  always_comb begin
    unique case (kind_r)
      K_VERS:   begin want = wanted_version; kflag = 3'b001; end
      K_GROUPS: begin want = wanted_group;   kflag = 3'b010; end
      default:  begin want = wanted_sig;     kflag = 3'b100; end
    endcase
    unique case (ph_r)
      PH_TYPE, PH_SIDLEN, PH_COMPLEN, PH_COMPBYTE, PH_ALPNLEN, PH_SNITYPE: w = 2'd1;
      PH_BODYLEN: w = 2'd3;
      PH_PREFIX: w = (kind_r == K_VERS) ? 2'd1 : 2'd2;
      PH_LEGACY, PH_CSLEN, PH_CSITEM, PH_EXTSLEN, PH_EXTTYPE, PH_EXTLEN,
      PH_U16ITEM, PH_KSGROUP, PH_KSLEN, PH_SNILEN: w = 2'd2;
      default: w = 2'd0;
    endcase
  end

  always_comb begin
    ph_nxt = ph_r; body_nxt = body_r; blk_nxt = blk_r; ext_nxt = ext_r;
    list_nxt = list_r; ent_nxt = ent_r; sh_nxt = sh_r; got_nxt = got_r;
    kind_nxt = kind_r; cmp_nxt = cmp_r; err_nxt = err_r; hit_nxt = hit_r;
    fl_nxt = fl_r; ksp_nxt = ksp_r; hp_nxt = hp_r; hl_nxt = hl_r; sid_nxt = sid_r;
    seen4_nxt = seen4_r;
    stop = 1'b0;
    vd_nxt = '0;
    if (b_over) begin
      err_nxt = 1'b1;
    end else if (!err_r) begin
      // enclosing-length checks, outermost first
      if (seen4_r) begin
        if (body_r == '0) begin err_nxt = 1'b1; stop = 1'b1; end
        else body_nxt = body_r - 24'd1;
      end
      if (!stop && ph_r >= PH_EXTTYPE) begin
        if (blk_r == '0) begin err_nxt = 1'b1; stop = 1'b1; end
        else blk_nxt = blk_r - 16'd1;
      end
      if (!stop && ph_r >= PH_SKIPEXT) begin
        if (ext_r == '0) begin err_nxt = 1'b1; stop = 1'b1; end
        else ext_nxt = ext_r - 16'd1;
      end
      if (!stop && (ph_r >= PH_U16ITEM || ph_r == PH_CSITEM)) begin
        if (list_r == '0) begin err_nxt = 1'b1; stop = 1'b1; end
        else list_nxt = list_r - 16'd1;
      end
      if (!stop && w == 2'd0) begin
        if (ent_r == '0) begin
          err_nxt = 1'b1;
        end else begin
          ent_nxt = ent_r - 16'd1;
          if (ph_r == PH_ALPNDATA) begin
            if (cmp_r >= 5'd1 && cmp_r <= 5'd8 && b_data == http11_char(cmp_r - 5'd1))
              cmp_nxt = cmp_r + 5'd1;
            else cmp_nxt = 5'd0;
          end
          if (ent_r == 16'd1) begin
            sh_nxt = '0; got_nxt = '0;
            priority case (ph_r)
              PH_RANDOM: ph_nxt = PH_SIDLEN;
              PH_SID:    ph_nxt = PH_CSLEN;
              PH_SKIPEXT: ph_nxt = PH_EXTTYPE;
              PH_KSDATA: ph_nxt = (list_nxt == '0) ? PH_EXTTYPE : PH_KSGROUP;
              PH_ALPNDATA: begin
                if (cmp_nxt == 5'd9) fl_nxt[5] = 1'b1;
                ph_nxt = (list_nxt == '0) ? PH_EXTTYPE : PH_ALPNLEN;
              end
              default: ph_nxt = (list_nxt == '0) ? PH_EXTTYPE : PH_SNITYPE;
            endcase
          end
        end
      end else if (!stop) begin
        sh_nxt = v;
        got_nxt = got_r + 2'd1;
        if (got_nxt >= w) begin
          // field complete; shift/got are cleared, but a session id length error keeps them
          sh_nxt = '0; got_nxt = '0;
          unique case (ph_r)
            PH_TYPE: begin if (v != 24'd1) err_nxt = 1'b1; ph_nxt = PH_BODYLEN; end
            PH_BODYLEN: begin body_nxt = v; ph_nxt = PH_LEGACY; end
            PH_LEGACY: begin ent_nxt = 16'd32; ph_nxt = PH_RANDOM; end
            PH_SIDLEN: begin
              if (v > 24'd32) begin err_nxt = 1'b1; sh_nxt = v; got_nxt = got_r + 2'd1; end
              else begin
                sid_nxt = v[5:0]; ent_nxt = v16;
                ph_nxt = (v == '0) ? PH_CSLEN : PH_SID;
              end
            end
            PH_CSLEN: begin
              if (v < 24'd2 || v[0]) err_nxt = 1'b1;
              else begin list_nxt = v16; fl_nxt[3] = 1'b0; ph_nxt = PH_CSITEM; end
            end
            PH_CSITEM: begin
              if (v16 == wanted_suite) fl_nxt[3] = 1'b1;
              ph_nxt = (list_nxt == '0) ? PH_COMPLEN : PH_CSITEM;
            end
            PH_COMPLEN: begin if (v != 24'd1) err_nxt = 1'b1; ph_nxt = PH_COMPBYTE; end
            PH_COMPBYTE: begin if (v != 24'd0) err_nxt = 1'b1; ph_nxt = PH_EXTSLEN; end
            PH_EXTSLEN: begin blk_nxt = v16; ph_nxt = PH_EXTTYPE; end
            PH_EXTTYPE: begin
              priority case (v16)
                ExtVersions: kind_nxt = K_VERS;
                ExtGroups:   kind_nxt = K_GROUPS;
                ExtSigs:     kind_nxt = K_SIGS;
                ExtKeyShare: kind_nxt = K_KEYSHARE;
                ExtAlpn:     kind_nxt = K_ALPN;
                ExtSni:      kind_nxt = K_SNI;
                default:     kind_nxt = K_OTHER;
              endcase
              ph_nxt = PH_EXTLEN;
            end
            PH_EXTLEN: begin
              if (v16 > blk_nxt) err_nxt = 1'b1;
              else begin
                ext_nxt = v16; ent_nxt = v16;
                if (kind_r != K_OTHER) ph_nxt = PH_PREFIX;
                else ph_nxt = (v16 == '0) ? PH_EXTTYPE : PH_SKIPEXT;
              end
            end
            PH_PREFIX: begin
              if (v16 != ext_nxt) err_nxt = 1'b1;
              else begin
                list_nxt = v16;
                if (kind_r <= K_SIGS) begin
                  if (v16[0]) err_nxt = 1'b1;
                  else begin
                    fl_nxt[2:0] = fl_r[2:0] & ~kflag;
                    ph_nxt = (v16 == '0) ? PH_EXTTYPE : PH_U16ITEM;
                  end
                end else if (kind_r == K_KEYSHARE) begin
                  ph_nxt = (v16 == '0) ? PH_EXTTYPE : PH_KSGROUP;
                end else if (kind_r == K_ALPN) begin
                  if (v16 == '0) err_nxt = 1'b1;
                  else begin fl_nxt[4] = 1'b1; ph_nxt = PH_ALPNLEN; end
                end else begin
                  ph_nxt = (v16 == '0) ? PH_EXTTYPE : PH_SNITYPE;
                end
              end
            end
            PH_U16ITEM: begin
              if (v16 == want) fl_nxt[2:0] = fl_r[2:0] | kflag;
              ph_nxt = (list_nxt == '0) ? PH_EXTTYPE : PH_U16ITEM;
            end
            PH_KSGROUP: begin hit_nxt = (v16 == wanted_group); ph_nxt = PH_KSLEN; end
            PH_KSLEN: begin
              if (v16 == '0 || v16 > list_nxt) err_nxt = 1'b1;
              else begin
                if (hit_r && v16 == KeyLen) begin fl_nxt[6] = 1'b1; ksp_nxt = p1; end
                ent_nxt = v16; ph_nxt = PH_KSDATA;
              end
            end
            PH_ALPNLEN: begin
              if (v16 == '0 || v16 > list_nxt) err_nxt = 1'b1;
              else begin
                cmp_nxt = (v16 == 16'd8) ? 5'd1 : 5'd0;
                ent_nxt = v16; ph_nxt = PH_ALPNDATA;
              end
            end
            PH_SNITYPE: begin hit_nxt = (v16 == '0); ph_nxt = PH_SNILEN; end
            PH_SNILEN: begin
              if (v16 > list_nxt) err_nxt = 1'b1;
              else begin
                if (hit_r && hl_r == '0 && v16 != '0) begin hp_nxt = p1; hl_nxt = v16; end
                ent_nxt = v16;
                if (v16 == '0) ph_nxt = (list_nxt == '0) ? PH_EXTTYPE : PH_SNITYPE;
                else ph_nxt = PH_SNIDATA;
              end
            end
            default: err_nxt = 1'b1;
          endcase
        end
      end
    end
    if (b_pos == 16'd3 && !b_over) seen4_nxt = 1'b1;
    if (!err_nxt && ph_nxt == PH_EXTTYPE && got_nxt == '0 && blk_nxt == '0 &&
        body_nxt == '0) begin
      vd_nxt.accepted          = 1'b1;
      vd_nxt.offers_version    = fl_nxt[0];
      vd_nxt.offers_group      = fl_nxt[1];
      vd_nxt.offers_sig_scheme = fl_nxt[2];
      vd_nxt.offers_suite      = fl_nxt[3];
      vd_nxt.alpn_seen         = fl_nxt[4];
      vd_nxt.alpn_has_http11   = fl_nxt[5];
      vd_nxt.session_id_length = sid_nxt;
      vd_nxt.key_share_found   = fl_nxt[6];
      vd_nxt.key_share_offset  = ksp_nxt;
      vd_nxt.host_name_offset  = hp_nxt;
      vd_nxt.host_name_length  = hl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_TYPE; got_r <= '0; err_r <= 1'b0; fl_r <= '0; seen4_r <= 1'b0;
      vv_r <= 1'b0;
      body_r <= '0; blk_r <= '0; ext_r <= '0; list_r <= '0; ent_r <= '0;
      sh_r <= '0; kind_r <= K_OTHER; cmp_r <= '0; hit_r <= 1'b0;
      ksp_r <= '0; hp_r <= '0; hl_r <= '0; sid_r <= '0;
    end else begin
      if (fire && b_fin) vv_r <= 1'b1;
      else if (v_ready) vv_r <= 1'b0;
      if (fire) begin
        if (b_fin) begin
          vd_r <= vd_nxt;
          ph_r <= PH_TYPE; got_r <= '0; err_r <= 1'b0; fl_r <= '0; seen4_r <= 1'b0;
          body_r <= '0; blk_r <= '0; ext_r <= '0; list_r <= '0; ent_r <= '0;
          sh_r <= '0; kind_r <= K_OTHER; cmp_r <= '0; hit_r <= 1'b0;
          ksp_r <= '0; hp_r <= '0; hl_r <= '0; sid_r <= '0;
        end else begin
          ph_r <= ph_nxt; got_r <= got_nxt; err_r <= err_nxt; fl_r <= fl_nxt;
          seen4_r <= seen4_nxt;
          body_r <= body_nxt; blk_r <= blk_nxt; ext_r <= ext_nxt; list_r <= list_nxt;
          ent_r <= ent_nxt; sh_r <= sh_nxt; kind_r <= kind_nxt; cmp_r <= cmp_nxt;
          hit_r <= hit_nxt; ksp_r <= ksp_nxt; hp_r <= hp_nxt; hl_r <= hl_nxt;
          sid_r <= sid_nxt;
        end
      end
    end
  end
endmodule

// File: hw/rtl/tls13_client_hello_checker.sv
// Top level of the TLS 1.3 ClientHello checker.
// Feed a ClientHello one byte per item, final_byte set on its last byte; that
// item yields one verdict, all other items none. Bytes are accepted one per
// clock: the intake counts the byte offset and hands bytes through a two-entry
// queue to the parser, which advances its length counters and field decoder
// by one byte each cycle; the verdict sits in an output register, so up to two
// bytes of the next message can enter the queue while it waits, after which
// input stalls until the verdict is taken. The verdict is registered when the
// parser takes the final byte from the queue. Messages longer than MAX_MSG_BYTES are
// rejected, and a rejected verdict carries zeros in every other field.
// Registers 0..3 set the wanted group, suite, signature scheme and version;
// write them only while the block is idle.
module tls13_client_hello_checker
  import tlsch_pkg::*;
#(
  parameter int MAX_MSG_BYTES = MaxMsgBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_offers_version,
  output logic        out_offers_group,
  output logic        out_offers_sig_scheme,
  output logic        out_offers_suite,
  output logic        out_alpn_seen,
  output logic        out_alpn_has_http11,
  output logic [5:0]  out_session_id_length,
  output logic        out_key_share_found,
  output logic [15:0] out_key_share_offset,
  output logic [15:0] out_host_name_offset,
  output logic [15:0] out_host_name_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] group_r, suite_r, sig_r, vers_r;
  qitem_t      f_item, q_item;
  logic        f_valid, f_ready, f_over, q_valid, q_ready;
  logic [15:0] f_pos;
  // over flag and offset travel alongside the byte in the queue
  logic [16:0] side_r [2];
  logic        sw_r, sr_r;
  verdict_t    vd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= 16'd29; suite_r <= 16'd4867; sig_r <= 16'd2055; vers_r <= 16'd772;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgGroup:   group_r <= cfg_data;
        CfgSuite:   suite_r <= cfg_data;
        CfgSig:     sig_r   <= cfg_data;
        CfgVersion: vers_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  tlsch_front #(.MAX_MSG_BYTES(MAX_MSG_BYTES)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_msg_byte, .in_final_byte,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item), .q_over(f_over), .q_pos(f_pos)
  );

  tlsch_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  always_ff @(posedge clk) begin
    if (f_valid && f_ready) side_r[sw_r] <= {f_over, f_pos};
    if (!rst_n) begin
      sw_r <= 1'b0; sr_r <= 1'b0;
    end else begin
      if (f_valid && f_ready) sw_r <= ~sw_r;
      if (q_valid && q_ready) sr_r <= ~sr_r;
    end
  end

  tlsch_back u_back (
    .clk, .rst_n, .b_valid(q_valid), .b_ready(q_ready), .b_data(q_item.data),
    .b_fin(q_item.fin), .b_over(side_r[sr_r][16]), .b_pos(side_r[sr_r][15:0]),
    .wanted_group(group_r), .wanted_suite(suite_r), .wanted_sig(sig_r),
    .wanted_version(vers_r), .v_valid(out_valid), .v_ready(out_ready), .v_data(vd)
  );

  assign out_accepted          = vd.accepted;
  assign out_offers_version    = vd.offers_version;
  assign out_offers_group      = vd.offers_group;
  assign out_offers_sig_scheme = vd.offers_sig_scheme;
  assign out_offers_suite      = vd.offers_suite;
  assign out_alpn_seen         = vd.alpn_seen;
  assign out_alpn_has_http11   = vd.alpn_has_http11;
  assign out_session_id_length = vd.session_id_length;
  assign out_key_share_found   = vd.key_share_found;
  assign out_key_share_offset  = vd.key_share_offset;
  assign out_host_name_offset  = vd.host_name_offset;
  assign out_host_name_length  = vd.host_name_length;
endmodule

// File: bench/testbench.sv
// Self-checking bench for the ClientHello checker: byte-stream stimulus, verdict scoreboard.
module testbench;
  import tlsch_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 8;     // extra drain margin after the last verdict
  localparam int RandomBytes = 1600;
  localparam int MinMessages = 48;

  // flag bits of the verdict summary
  localparam bit [6:0] F_VERSION = 7'd1, F_GROUP = 7'd2, F_SIG = 7'd4, F_SUITE = 7'd8,
                       F_ALPN = 7'd16, F_HTTP11 = 7'd32, F_KEYSHARE = 7'd64;

  localparam bit [7:0] HTTP11 [8] = '{8'h68, 8'h74, 8'h74, 8'h70, 8'h2f, 8'h31, 8'h2e, 8'h31};

  // Pending verdicts, oldest first; compares each arriving verdict field by field.
  class VerdictBoard;
    verdict_t due[$];
    int errors = 0;

    function void note(verdict_t v);
      due.push_back(v);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        $error("verdict arrived with none pending");
        errors++;
        return;
      end
      want = due.pop_front();
      cmp("accepted", want.accepted, got.accepted);
      cmp("offers_version", want.offers_version, got.offers_version);
      cmp("offers_group", want.offers_group, got.offers_group);
      cmp("offers_sig_scheme", want.offers_sig_scheme, got.offers_sig_scheme);
      cmp("offers_suite", want.offers_suite, got.offers_suite);
      cmp("alpn_seen", want.alpn_seen, got.alpn_seen);
      cmp("alpn_has_http11", want.alpn_has_http11, got.alpn_has_http11);
      cmp("session_id_length", want.session_id_length, got.session_id_length);
      cmp("key_share_found", want.key_share_found, got.key_share_found);
      cmp("key_share_offset", want.key_share_offset, got.key_share_offset);
      cmp("host_name_offset", want.host_name_offset, got.host_name_offset);
      cmp("host_name_length", want.host_name_length, got.host_name_length);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_msg_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted, out_offers_version, out_offers_group, out_offers_sig_scheme;
  logic        out_offers_suite, out_alpn_seen, out_alpn_has_http11, out_key_share_found;
  logic [5:0]  out_session_id_length;
  logic [15:0] out_key_share_offset, out_host_name_offset, out_host_name_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CfgGroup;
  logic [15:0] cfg_data = 16'h0000;

  tls13_client_hello_checker DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  VerdictBoard board = new();
  int unsigned cycles = 0;
  int burst_left = 0;

  // ---------------------------------------------------------------------
  // Predictor: the parser's state, advanced one byte per accepted item
  // ---------------------------------------------------------------------
  bit [15:0] want_group = 16'd29, want_suite = 16'd4867;
  bit [15:0] want_sig = 16'd2055, want_ver = 16'd772;
  bit [16:0] pos_cnt, cur_pos;
  phase_t    ph_r;
  kind_t     kind_r;
  bit [23:0] body_left, shift_r;
  bit [15:0] blk_left, ext_left, list_left, entry_left;
  bit [4:0]  alpn_cmp;
  bit        err, hit;
  bit [6:0]  flags;
  bit [15:0] ks_pos, host_pos, host_len;
  bit [5:0]  sid_len;
  int        got;

  function automatic void clear_msg();
    pos_cnt = 0; ph_r = PH_TYPE; body_left = 0; blk_left = 0; ext_left = 0;
    list_left = 0; entry_left = 0; shift_r = 0; kind_r = K_OTHER; alpn_cmp = 0;
    err = 0; flags = 0; ks_pos = 0; host_pos = 0; host_len = 0; got = 0;
    sid_len = 0; hit = 0;
  endfunction

  function automatic void goto_phase(phase_t p);
    ph_r = p;
    shift_r = 0;
    got = 0;
  endfunction

  // a list that runs out hands over to the next extension header
  function automatic void list_next(phase_t p);
    goto_phase(list_left == 0 ? PH_EXTTYPE : p);
  endfunction

  function automatic int width_of(phase_t p);
    case (p)
      PH_TYPE, PH_SIDLEN, PH_COMPLEN, PH_COMPBYTE, PH_ALPNLEN, PH_SNITYPE: return 1;
      PH_BODYLEN: return 3;
      PH_PREFIX: return kind_r == K_VERS ? 1 : 2;
      PH_LEGACY, PH_CSLEN, PH_CSITEM, PH_EXTSLEN, PH_EXTTYPE, PH_EXTLEN, PH_U16ITEM,
      PH_KSGROUP, PH_KSLEN, PH_SNILEN: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic bit [6:0] list_flag();
    return kind_r == K_VERS ? F_VERSION : kind_r == K_GROUPS ? F_GROUP : F_SIG;
  endfunction

  function automatic bit [15:0] list_wanted();
    return kind_r == K_VERS ? want_ver : kind_r == K_GROUPS ? want_group : want_sig;
  endfunction

  // a complete length or code field has been gathered
  function automatic void field_done(phase_t p, bit [23:0] v);
    case (p)
      PH_TYPE: begin
        if (v != 1) err = 1;
        goto_phase(PH_BODYLEN);
      end
      PH_BODYLEN: begin
        body_left = v;
        goto_phase(PH_LEGACY);
      end
      PH_LEGACY: begin
        entry_left = 32;
        goto_phase(PH_RANDOM);
      end
      PH_SIDLEN: begin
        if (v > 32) begin
          err = 1;
          return;
        end
        sid_len = v[5:0];
        entry_left = v[15:0];
        goto_phase(v == 0 ? PH_CSLEN : PH_SID);
      end
      PH_CSLEN: begin
        if (v < 2 || v[0]) begin
          err = 1;
          return;
        end
        list_left = v[15:0];
        flags &= ~F_SUITE;
        goto_phase(PH_CSITEM);
      end
      PH_CSITEM: begin
        if (v == want_suite) flags |= F_SUITE;
        goto_phase(list_left == 0 ? PH_COMPLEN : PH_CSITEM);
      end
      PH_COMPLEN: begin
        if (v != 1) err = 1;
        goto_phase(PH_COMPBYTE);
      end
      PH_COMPBYTE: begin
        if (v != 0) err = 1;
        goto_phase(PH_EXTSLEN);
      end
      PH_EXTSLEN: begin
        blk_left = v[15:0];
        goto_phase(PH_EXTTYPE);
      end
      PH_EXTTYPE: begin
        case (v[15:0])
          ExtVersions: kind_r = K_VERS;
          ExtGroups:   kind_r = K_GROUPS;
          ExtSigs:     kind_r = K_SIGS;
          ExtKeyShare: kind_r = K_KEYSHARE;
          ExtAlpn:     kind_r = K_ALPN;
          ExtSni:      kind_r = K_SNI;
          default:     kind_r = K_OTHER;
        endcase
        goto_phase(PH_EXTLEN);
      end
      PH_EXTLEN: begin
        if (v > blk_left) begin
          err = 1;
          return;
        end
        ext_left = v[15:0];
        entry_left = v[15:0];
        if (kind_r != K_OTHER) goto_phase(PH_PREFIX);
        else goto_phase(v == 0 ? PH_EXTTYPE : PH_SKIPEXT);
      end
      PH_PREFIX: begin
        if (v != ext_left) begin
          err = 1;
          return;
        end
        list_left = v[15:0];
        if (kind_r <= K_SIGS) begin
          if (v[0]) begin
            err = 1;
            return;
          end
          flags &= ~list_flag();
          list_next(PH_U16ITEM);
        end else if (kind_r == K_KEYSHARE) begin
          list_next(PH_KSGROUP);
        end else if (kind_r == K_ALPN) begin
          if (v == 0) begin
            err = 1;
            return;
          end
          flags |= F_ALPN;
          goto_phase(PH_ALPNLEN);
        end else begin
          list_next(PH_SNITYPE);
        end
      end
      PH_U16ITEM: begin
        if (v == list_wanted()) flags |= list_flag();
        list_next(PH_U16ITEM);
      end
      PH_KSGROUP: begin
        hit = (v == want_group);
        goto_phase(PH_KSLEN);
      end
      PH_KSLEN: begin
        if (v == 0 || v > list_left) begin
          err = 1;
          return;
        end
        if (hit && v == KeyLen) begin  // last matching x25519-sized key wins
          flags |= F_KEYSHARE;
          ks_pos = 16'(cur_pos + 1);
        end
        entry_left = v[15:0];
        goto_phase(PH_KSDATA);
      end
      PH_ALPNLEN: begin
        if (v == 0 || v > list_left) begin
          err = 1;
          return;
        end
        alpn_cmp = (v == 8) ? 5'd1 : 5'd0;
        entry_left = v[15:0];
        goto_phase(PH_ALPNDATA);
      end
      PH_SNITYPE: begin
        hit = (v == 0);
        goto_phase(PH_SNILEN);
      end
      PH_SNILEN: begin
        if (v > list_left) begin
          err = 1;
          return;
        end
        if (hit && host_len == 0 && v > 0) begin  // first host name wins
          host_pos = 16'(cur_pos + 1);
          host_len = v[15:0];
        end
        entry_left = v[15:0];
        if (v == 0) list_next(PH_SNITYPE);
        else goto_phase(PH_SNIDATA);
      end
      default: err = 1;
    endcase
  endfunction

  // end of an opaque run of bytes
  function automatic void run_done(phase_t p);
    case (p)
      PH_RANDOM:  goto_phase(PH_SIDLEN);
      PH_SID:     goto_phase(PH_CSLEN);
      PH_SKIPEXT: goto_phase(PH_EXTTYPE);
      PH_KSDATA:  list_next(PH_KSGROUP);
      PH_ALPNDATA: begin
        if (alpn_cmp == 9) flags |= F_HTTP11;
        list_next(PH_ALPNLEN);
      end
      default: list_next(PH_SNITYPE);
    endcase
  endfunction

  function automatic void take_byte(bit [7:0] b);
    phase_t p;
    int w;
    p = ph_r;
    // every enclosing vector must still have room for this byte
    if (cur_pos >= 4) begin
      if (body_left == 0) begin
        err = 1;
        return;
      end
      body_left--;
    end
    if (p >= PH_EXTTYPE) begin
      if (blk_left == 0) begin
        err = 1;
        return;
      end
      blk_left--;
    end
    if (p >= PH_SKIPEXT) begin
      if (ext_left == 0) begin
        err = 1;
        return;
      end
      ext_left--;
    end
    if (p >= PH_U16ITEM || p == PH_CSITEM) begin
      if (list_left == 0) begin
        err = 1;
        return;
      end
      list_left--;
    end
    w = width_of(p);
    if (w == 0) begin
      if (entry_left == 0) begin
        err = 1;
        return;
      end
      entry_left--;
      if (p == PH_ALPNDATA) begin
        if (alpn_cmp >= 1 && alpn_cmp <= 8 && b == HTTP11[alpn_cmp - 1]) alpn_cmp++;
        else alpn_cmp = 0;
      end
      if (entry_left == 0) run_done(p);
      return;
    end
    shift_r = {shift_r[15:0], b};
    got++;
    if (got >= w) field_done(p, shift_r);
  endfunction

  // advance by one accepted byte; on the final byte, hand back the verdict
  function automatic bit step_hello(bit [7:0] b, bit fin, output verdict_t vd);
    bit ok;
    vd = '0;
    if (pos_cnt >= MaxMsgBytes) begin
      err = 1;  // too long
    end else begin
      cur_pos = pos_cnt;
      pos_cnt++;
      if (!err) take_byte(b);
    end
    if (!fin) return 1'b0;
    ok = !err && ph_r == PH_EXTTYPE && got == 0 && blk_left == 0 && body_left == 0;
    if (ok) begin
      vd.accepted          = 1'b1;
      vd.offers_version    = |(flags & F_VERSION);
      vd.offers_group      = |(flags & F_GROUP);
      vd.offers_sig_scheme = |(flags & F_SIG);
      vd.offers_suite      = |(flags & F_SUITE);
      vd.alpn_seen         = |(flags & F_ALPN);
      vd.alpn_has_http11   = |(flags & F_HTTP11);
      vd.session_id_length = sid_len;
      vd.key_share_found   = |(flags & F_KEYSHARE);
      vd.key_share_offset  = ks_pos;
      vd.host_name_offset  = host_pos;
      vd.host_name_length  = host_len;
    end
    clear_msg();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Message builder
  // ---------------------------------------------------------------------
  function automatic void push16(ref bit [7:0] q[$], input int unsigned v);
    q.push_back(v[15:8]);
    q.push_back(v[7:0]);
  endfunction

  // the wanted code a third of the time, otherwise an edge value or noise
  function automatic bit [15:0] pick_code(bit [15:0] wanted);
    case ($urandom_range(0, 5))
      0, 1: return wanted;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // random, mostly well formed ClientHello; about one in five gets broken
  function automatic void build_hello(ref bit [7:0] msg[$]);
    bit [7:0] body[$], blk[$], ed[$], lst[$];
    int n, sid, len, kind;
    body = {};
    blk = {};
    push16(body, $urandom);
    repeat (32) body.push_back(8'($urandom));
    sid = $urandom_range(0, 32);
    body.push_back(8'(sid));
    repeat (sid) body.push_back(8'($urandom));
    n = $urandom_range(1, 6);
    push16(body, 2 * n);
    repeat (n) push16(body, pick_code(want_suite));
    body.push_back(8'd1);
    body.push_back(8'd0);
    repeat ($urandom_range(0, 5)) begin
      ed = {};
      lst = {};
      kind = $urandom_range(0, 7);
      case (kind)
        0, 1, 2: begin  // supported versions / groups / signature algorithms
          n = $urandom_range(0, 4);
          repeat (n) push16(lst, pick_code(kind == 0 ? want_ver :
                                           kind == 1 ? want_group : want_sig));
          if (kind == 0) ed.push_back(8'(lst.size()));
          else push16(ed, lst.size());
        end
        3: begin  // key shares
          repeat ($urandom_range(0, 2)) begin
            push16(lst, pick_code(want_group));
            len = $urandom_range(0, 2) != 0 ? 32 : $urandom_range(1, 40);
            push16(lst, len);
            repeat (len) lst.push_back(8'($urandom));
          end
          push16(ed, lst.size());
        end
        4: begin  // ALPN names, near misses of http/1.1 included
          repeat ($urandom_range(1, 3)) begin
            n = $urandom_range(0, 3);
            len = n == 0 ? 8 : n == 1 ? 7 : n == 2 ? 9 : $urandom_range(1, 10);
            lst.push_back(8'(len));
            for (int i = 0; i < len; i++)
              lst.push_back((n <= 2 && i < 8) ? HTTP11[i] : 8'($urandom));
          end
          push16(ed, lst.size());
        end
        5: begin  // server names
          repeat ($urandom_range(0, 2)) begin
            lst.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd0);
            len = $urandom_range(0, 12);
            push16(lst, len);
            repeat (len) lst.push_back(8'($urandom));
          end
          push16(ed, lst.size());
        end
        default: begin  // unknown type, opaque contents
          repeat ($urandom_range(0, 6)) lst.push_back(8'($urandom));
        end
      endcase
      ed = {ed, lst};
      case (kind)
        0: push16(blk, ExtVersions);
        1: push16(blk, ExtGroups);
        2: push16(blk, ExtSigs);
        3: push16(blk, ExtKeyShare);
        4: push16(blk, ExtAlpn);
        5: push16(blk, ExtSni);
        6: push16(blk, $urandom);
        default: push16(blk, 16'h0015);
      endcase
      push16(blk, ed.size());
      blk = {blk, ed};
    end
    push16(body, blk.size());
    body = {body, blk};
    msg = {8'd1, 8'(body.size() >> 16), 8'(body.size() >> 8), 8'(body.size()), body};
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
        1: void'(msg.pop_back());
        default: msg.push_back(8'($urandom));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic send_item(input bit [7:0] b, input bit fin);
    verdict_t vd;
    in_valid <= 1'b1;
    in_msg_byte <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (step_hello(b, fin, vd)) board.note(vd);
    @(negedge clk);
    // bursts of random length, occasionally long unbroken runs
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(100, 400) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_msg(ref bit [7:0] msg[$]);
    foreach (msg[i]) send_item(msg[i], i == msg.size() - 1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CfgGroup:   want_group = val;
      CfgSuite:   want_suite = val;
      CfgSig:     want_sig = val;
      default:    want_ver = val;
    endcase
    @(negedge clk);
  endtask

  // input side quiet, all verdicts in, then the DrainCycles margin for the pipeline
  task automatic drain();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // receiver: stall pattern is redrawn periodically among four modes
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= $urandom_range(0, 3) == 0;
      default: out_ready <= cycles[0];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check('{out_accepted, out_offers_version, out_offers_group,
                    out_offers_sig_scheme, out_offers_suite, out_alpn_seen,
                    out_alpn_has_http11, out_session_id_length, out_key_share_found,
                    out_key_share_offset, out_host_name_offset, out_host_name_length});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[tls13_client_hello_checker] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    bit [7:0] msg[$];
    int sent, msgs;
    bit [15:0] vals [4];
    clear_msg();
    cur_pos = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one-byte messages and a minimal hello
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    send_item(8'h01, 1'b1);
    msg = {8'd1, 8'd0, 8'd0, 8'd41, 8'h03, 8'h03};
    repeat (32) msg.push_back(8'h00);
    msg = {msg, 8'd0, 8'd0, 8'd2, 8'h13, 8'h03, 8'd1, 8'd0, 8'd0, 8'd0};
    send_msg(msg);

    // random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: vals = '{16'd29, 16'd4867, 16'd2055, 16'd772};
        1: vals = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        2: vals = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
        default: vals = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      write_reg(CfgGroup, vals[0]);
      write_reg(CfgSuite, vals[1]);
      write_reg(CfgSig, vals[2]);
      write_reg(CfgVersion, vals[3]);
      cfg_valid <= 1'b0;
      @(negedge clk);
      sent = 0;
      msgs = 0;
      while (sent < RandomBytes / 5 || msgs < MinMessages / 5 + 1) begin
        build_hello(msg);
        send_msg(msg);
        sent += msg.size();
        msgs++;
      end
    end

    drain();
    if (board.errors == 0)
      $display("[tls13_client_hello_checker] OK");
    else
      $display("[tls13_client_hello_checker] ERROR");
    $finish;
  end

endmodule
